[hw/rtl/sne_pkg.sv]
// ----------------------------------------------------------------------------
// sne_pkg: shared types and constants of the 8.3 short name encoder
// Character codes, name field sizes, the base/segment container type and
// the character mapping function.
// ----------------------------------------------------------------------------
`default_nettype none

package sne_pkg;

    // Default limit on bytes of one name, the terminating NUL included
    localparam int NAME_LIMIT_DEF = 64;

    // Field sizes of an 8.3 name
    localparam int BASE_LEN = 8;
    localparam int EXT_LEN  = 3;
    localparam int FILL_W   = 4;

    // Character codes
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    localparam logic [BASE_LEN*8-1:0] SPACES_BASE = {BASE_LEN{CH_SPACE}};
    localparam logic [EXT_LEN*8-1:0]  SPACES_EXT  = {EXT_LEN{CH_SPACE}};

    // A run of up to eight characters and how many of them are filled
    typedef struct packed {
        logic [BASE_LEN*8-1:0] bytes;
        logic [FILL_W-1:0]     fill;
    } t_part;

    // Fold lowercase to uppercase, replace characters illegal in 8.3 names
    function automatic logic [7:0] map_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == 8'h2B || c == 8'h2C || c == 8'h3B || c == 8'h3D ||
            c == 8'h5B || c == 8'h5D) begin
            r = CH_UNDERSCORE;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/sne_merge.sv]
// ----------------------------------------------------------------------------
// sne_merge: append the current segment to the base
// Combinational merge: segment characters fill the base positions after its
// current fill, up to eight characters in total.
// ----------------------------------------------------------------------------
`default_nettype none

module sne_merge (
    input  var sne_pkg::t_part i_base,
    input  var sne_pkg::t_part i_seg,
    output sne_pkg::t_part     o_merged
);

    localparam int FW = sne_pkg::FILL_W;

    logic [FW:0] sum;

    // Full sum of both fills, saturated below
    assign sum = {1'b0, i_base.fill} + {1'b0, i_seg.fill};

    // Per base position: keep, take a segment byte, or keep the padding
    always_comb begin
        logic [FW-1:0] idx;
        o_merged.bytes = i_base.bytes;
        for (int j = 0; j < sne_pkg::BASE_LEN; j++) begin
            idx = FW'(j) - i_base.fill;
            if (FW'(j) >= i_base.fill && idx < i_seg.fill) begin
                o_merged.bytes[j*8 +: 8] = i_seg.bytes[idx[2:0]*8 +: 8];
            end
        end
        // New fill saturates at the base length
        o_merged.fill = (sum > (FW+1)'(sne_pkg::BASE_LEN)) ?
                        FW'(sne_pkg::BASE_LEN) : sum[FW-1:0];
    end

endmodule

`default_nettype wire

[hw/rtl/short_name_83_encoder.sv]
// ----------------------------------------------------------------------------
// short_name_83_encoder: file name to 8.3 short name
// Takes a name one byte per request and delivers the 8.3 base and extension
// when the terminating NUL byte arrives.
// ----------------------------------------------------------------------------
// One byte is taken every cycle while o_stall is low. Each byte is held in an
// input register, and in the next cycle the name state (base, current segment,
// dot flag, length) is updated by one pass of mapping and merge logic. A NUL
// byte in the input register loads the result register, and the name state
// returns to its reset value so the next name can follow right behind. The
// result register lets input continue while a result waits; only a NUL that
// finds the result register still stalled holds the input side. Bytes past the
// first NAME_LIMIT-1 of a name are ignored up to its NUL.
// ----------------------------------------------------------------------------
`default_nettype none

module short_name_83_encoder #(
    parameter int NAME_LIMIT = sne_pkg::NAME_LIMIT_DEF
) (
    input  var logic                              i_clk,
    input  var logic                              i_rst_n,
    input  var logic                              i_valid,
    output logic                                  o_stall,
    input  var logic [7:0]                        i_name_byte,
    output logic                                  o_valid,
    input  var logic                              i_stall,
    output logic [sne_pkg::BASE_LEN*8-1:0]        o_base_name,
    output logic [sne_pkg::EXT_LEN*8-1:0]         o_ext_name
);

    localparam int LEN_W = $clog2(NAME_LIMIT);
    localparam int FW    = sne_pkg::FILL_W;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_byte;

    // Name state
    sne_pkg::t_part r_base, n_base;
    sne_pkg::t_part r_seg,  n_seg;
    logic           r_dot,  n_dot;
    logic [LEN_W-1:0] r_len, n_len;

    // Result register
    logic                           r_out_valid;
    logic [sne_pkg::BASE_LEN*8-1:0] r_out_base;
    logic [sne_pkg::EXT_LEN*8-1:0]  r_out_ext;

    sne_pkg::t_part merged;
    logic           is_nul;
    logic           blocked;
    logic           advance;
    logic           emit;

    assign is_nul  = (r_byte == sne_pkg::CH_NUL);
    assign blocked = is_nul && r_out_valid && i_stall;
    assign advance = r_in_valid && !blocked;
    assign emit    = advance && is_nul;
    assign o_stall = r_in_valid && blocked;

    // Input register: loads whenever the held byte moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte <= i_name_byte;
        end
    end

    // Segment merge into the base
    sne_merge u_merge (
        .i_base   (r_base),
        .i_seg    (r_seg),
        .o_merged (merged)
    );

    // Next name state
    always_comb begin
        n_base = r_base;
        n_seg  = r_seg;
        n_dot  = r_dot;
        n_len  = r_len;
        if (advance) begin
            if (is_nul) begin
                n_base.bytes = sne_pkg::SPACES_BASE;
                n_base.fill  = '0;
                n_seg.bytes  = sne_pkg::SPACES_BASE;
                n_seg.fill   = '0;
                n_dot        = 1'b0;
                n_len        = '0;
            end else if (r_len != LEN_W'(NAME_LIMIT - 1)) begin
                n_len = r_len + 1'b1;
                if (r_byte == sne_pkg::CH_DOT) begin
                    n_base      = merged;
                    n_seg.bytes = sne_pkg::SPACES_BASE;
                    n_seg.fill  = '0;
                    n_dot       = 1'b1;
                end else if (r_seg.fill < FW'(sne_pkg::BASE_LEN)) begin
                    n_seg.bytes[r_seg.fill[2:0]*8 +: 8] = sne_pkg::map_char(r_byte);
                    n_seg.fill = r_seg.fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base.bytes <= sne_pkg::SPACES_BASE;
            r_base.fill  <= '0;
            r_seg.bytes  <= sne_pkg::SPACES_BASE;
            r_seg.fill   <= '0;
            r_dot        <= 1'b0;
            r_len        <= '0;
        end else begin
            r_base <= n_base;
            r_seg  <= n_seg;
            r_dot  <= n_dot;
            r_len  <= n_len;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_base <= r_dot ? r_base.bytes : merged.bytes;
            r_out_ext  <= r_dot ? r_seg.bytes[sne_pkg::EXT_LEN*8-1:0] : sne_pkg::SPACES_EXT;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_base_name = r_out_base;
    assign o_ext_name  = r_out_ext;

    // Checks
    a_base_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base.fill <= FW'(sne_pkg::BASE_LEN))
        else $error("base fill out of range");

    a_seg_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg.fill <= FW'(sne_pkg::BASE_LEN))
        else $error("segment fill out of range");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_base.fill == '0 && r_seg.fill == '0 && !r_dot && r_len == '0))
        else $error("name state not cleared after a result");

    a_rise_from_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_in_valid && is_nul))
        else $error("result without a terminating NUL");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled result dropped");

endmodule

`default_nettype wire
